// ----- hdl/wspc_pkg.sv -----
`timescale 1ns / 1ps
// Package: payload types, widths and register codes of the wheel speed PID unit.
package wspc_pkg;

	// Serial multiplier: wide magnitude times a 16-bit gain or tick
	localparam int MulAW = 40;
	localparam int MulBW = 16;
	localparam int MulPW = MulAW + MulBW;

	// Serial divider: left-aligned dividend, 16-bit divisor
	localparam int DivNW = 56;
	localparam int DivDW = 16;

	// Step counter wide enough for the longest serial pass
	localparam int CntW = 6;

	// Configuration register indexes
	localparam logic [2:0] CFG_GAIN_P       = 3'd0;
	localparam logic [2:0] CFG_GAIN_I       = 3'd1;
	localparam logic [2:0] CFG_GAIN_D       = 3'd2;
	localparam logic [2:0] CFG_INTEGRAL_CAP = 3'd3;
	localparam logic [2:0] CFG_MAX_SPEED    = 3'd4;
	localparam logic [2:0] CFG_MIN_WINDOW   = 3'd5;

	typedef struct packed {
		logic [1:0]         motor;
		logic signed [31:0] encoder_position;
		logic signed [15:0] target_speed;
		logic [15:0]        tick_ms;
		logic [15:0]        window_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]         motor_out;
		logic [7:0]         duty;
		logic signed [15:0] measured_speed;
	} rsp_t;

endpackage

// ----- hdl/wspc_mul.sv -----
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module wspc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wspc_pkg::MulAW-1:0]    mcand,
	input  logic [wspc_pkg::MulBW-1:0]    mplier,
	output logic                          done,
	output logic [wspc_pkg::MulPW-1:0]    product
);
	import wspc_pkg::*;

	logic [MulPW-1:0] mcand_q;
	logic [MulPW-1:0] acc_q;
	logic [MulBW-1:0] mplier_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;

	// Count the steps and flag the end of a pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(MulBW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Add the shifted multiplicand for each set multiplier bit
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= MulPW'(mcand);
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- hdl/wspc_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
module wspc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wspc_pkg::DivNW-1:0]    dividend,
	input  logic [wspc_pkg::DivDW-1:0]    divisor,
	input  logic [wspc_pkg::CntW-1:0]     steps,
	output logic                          done,
	output logic [wspc_pkg::DivNW-1:0]    quotient
);
	import wspc_pkg::*;

	logic [DivNW-1:0] num_q;
	logic [DivDW-1:0] rem_q;
	logic [DivDW-1:0] den_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DivDW:0]   trial;
	logic             fits;

	// Shift the next dividend bit into the remainder and try the divisor
	assign trial = {rem_q, num_q[DivNW-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits enter at the bottom as the dividend leaves the top
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DivDW'(trial - {1'b0, den_q}) : DivDW'(trial);
			num_q <= {num_q[DivNW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ----- hdl/wheel_speed_pid_controller_unit.sv -----
`timescale 1ns / 1ps
// Top level: per-motor PID speed controller with bit-serial multiply and divide.
// The speed is recomputed only for a valid window, the last divide is skipped when the duty
// clamps at 0 or 255, and the result waits while the output is stalled.
// One request at a time; the next can be taken in the cycle after the result is registered.
// The sequence runs on the shared serial divider (one quotient bit a cycle)
// and the shared serial multiplier (one gain or tick bit a cycle).
// Reset clears the per-motor state and loads the default gains and limits.
module wheel_speed_pid_controller_unit #(
	parameter int MOTORS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  wspc_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output wspc_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_data
);
	import wspc_pkg::*;

	localparam int MI   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam int AccW = 49;
	localparam int VW   = AccW - 6;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_LOAD = 13'b0000000000010,
		ST_SPD  = 13'b0000000000100,
		ST_ERR  = 13'b0000000001000,
		ST_DD   = 13'b0000000010000,
		ST_ET   = 13'b0000000100000,
		ST_P    = 13'b0000001000000,
		ST_D    = 13'b0000010000000,
		ST_I    = 13'b0000100000000,
		ST_IQ   = 13'b0001000000000,
		ST_U    = 13'b0010000000000,
		ST_DUTY = 13'b0100000000000,
		ST_DONE = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [15:0] gain_p_q, gain_i_q, gain_d_q, integral_cap_q, min_window_q;
	logic [14:0] max_speed_q;

	// Per-motor state
	logic signed [31:0] last_pos_q  [MOTORS];
	logic signed [15:0] speed_est_q [MOTORS];
	logic signed [17:0] last_err_q  [MOTORS];
	logic signed [39:0] err_integ_q [MOTORS];

	// Working registers of the request in flight
	req_t                req_q;
	logic signed [15:0]  spd_w_q;
	logic                diff_neg_q;
	logic signed [17:0]  e_q;
	logic                dd_neg_q;
	logic [26:0]         dedt_mag_q;
	logic signed [39:0]  integ_w_q;
	logic signed [AccW-1:0] acc_q;
	logic [7:0]          duty_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	// Serial unit hookup
	logic              mul_start, mul_done;
	logic [MulAW-1:0]  mul_a;
	logic [MulBW-1:0]  mul_b;
	logic [MulPW-1:0]  mul_prod;
	logic              div_start, div_done;
	logic [DivNW-1:0]  div_num, div_quot;
	logic [DivDW-1:0]  div_den;
	logic [CntW-1:0]   div_steps;

	logic [MI-1:0]      idx;
	logic               win_ok;
	logic [15:0]        tick1;
	logic signed [32:0] diff;
	logic [32:0]        diff_mag;
	logic [42:0]        diff_k;
	logic [14:0]        spd_sat;
	logic signed [15:0] spd_new;
	logic signed [17:0] e_raw, e_comb;
	logic [17:0]        e_mag;
	logic signed [18:0] dd;
	logic [18:0]        dd_mag;
	logic [26:0]        dd_k;
	logic signed [40:0] et_s, integ_sum, cap_s, integ_sat;
	logic [25:0]        cap;
	logic [39:0]        integ_mag;
	logic [AccW-1:0]    acc_mag;
	logic [AccW-9:0]    u_mag;
	logic signed [VW-1:0] u_s, v_s;
	logic [14:0]        ms;
	logic [15:0]        two_ms;
	logic               v_neg, v_big;
	logic [23:0]        v_k;
	logic               rsp_free;

	localparam logic signed [40:0] IntegMin = {2'b11, 39'd0};

	assign idx      = MI'(req_q.motor);
	assign win_ok   = (req_q.window_ms != 16'd0) && (req_q.window_ms >= min_window_q);
	assign tick1    = (req_q.tick_ms == 16'd0) ? 16'd1 : req_q.tick_ms;

	// Speed from the position change
	assign diff     = 33'(req_q.encoder_position) - 33'(last_pos_q[idx]);
	assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign diff_k   = 43'(diff_mag) * 43'(1000);
	assign spd_sat  = (div_quot > DivNW'(32767)) ? 15'd32767 : div_quot[14:0];
	assign spd_new  = diff_neg_q ? -$signed({1'b0, spd_sat}) : $signed({1'b0, spd_sat});

	// Error and its change since the last tick
	assign e_raw  = 18'(req_q.target_speed) - 18'(spd_w_q);
	assign e_comb = req_q.target_speed[15] ? -e_raw : e_raw;
	assign e_mag  = e_q[17] ? 18'(-e_q) : 18'(e_q);
	assign dd     = 19'(e_comb) - 19'(last_err_q[idx]);
	assign dd_mag = dd[18] ? 19'(-dd) : 19'(dd);
	assign dd_k   = 27'(dd_mag) * 27'(1000);

	// Integral update with its limits
	assign et_s      = e_q[17] ? -$signed(41'(mul_prod)) : $signed(41'(mul_prod));
	assign integ_sum = 41'(err_integ_q[idx]) + et_s;
	assign cap       = 26'(integral_cap_q) * 26'(1000);
	assign cap_s     = $signed(41'(cap));
	assign integ_sat = (integ_sum > cap_s) ? cap_s :
		((integ_sum < IntegMin) ? IntegMin : integ_sum);
	assign integ_mag = integ_w_q[39] ? 40'(-integ_w_q) : 40'(integ_w_q);

	// Scale the sum and map it onto the duty range
	assign acc_mag = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
	assign u_mag   = acc_mag[AccW-1:8];
	assign u_s     = acc_q[AccW-1] ? -$signed(VW'(u_mag)) : $signed(VW'(u_mag));
	assign ms      = (max_speed_q == 15'd0) ? 15'd1 : max_speed_q;
	assign two_ms  = {ms, 1'b0};
	assign v_s     = u_s + $signed(VW'(ms));
	assign v_neg   = v_s[VW-1];
	assign v_big   = !v_neg && (v_s >= $signed(VW'(two_ms)));
	assign v_k     = 24'(v_s[15:0]) * 24'(255);

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// Steer the serial units
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_steps = '0;
		case (state_q)
			ST_LOAD: begin
				if (win_ok) begin
					div_start = 1'b1;
					div_num   = {diff_k, 13'd0};
					div_den   = req_q.window_ms;
					div_steps = CntW'(43);
				end
			end
			ST_ERR: begin
				div_start = 1'b1;
				div_num   = {dd_k, 29'd0};
				div_den   = tick1;
				div_steps = CntW'(27);
			end
			ST_DD: begin
				mul_start = div_done;
				mul_a     = MulAW'(e_mag);
				mul_b     = tick1;
			end
			ST_ET: begin
				mul_start = mul_done;
				mul_a     = MulAW'(e_mag);
				mul_b     = gain_p_q;
			end
			ST_P: begin
				mul_start = mul_done;
				mul_a     = MulAW'(dedt_mag_q);
				mul_b     = gain_d_q;
			end
			ST_D: begin
				mul_start = mul_done;
				mul_a     = integ_mag;
				mul_b     = gain_i_q;
			end
			ST_I: begin
				div_start = mul_done;
				div_num   = mul_prod;
				div_den   = DivDW'(1000);
				div_steps = CntW'(DivNW);
			end
			ST_U: begin
				div_start = !v_neg && !v_big;
				div_num   = {v_k, 32'd0};
				div_den   = two_ms;
				div_steps = CntW'(24);
			end
			default: begin
			end
		endcase
	end

	wspc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_a),
		.mplier  (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	wspc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequencer, configuration and per-motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rsp_valid_q    <= 1'b0;
			gain_p_q       <= 16'd384;
			gain_i_q       <= 16'd512;
			gain_d_q       <= 16'd51;
			integral_cap_q <= 16'd800;
			max_speed_q    <= 15'd1600;
			min_window_q   <= 16'd100;
			for (int k = 0; k < MOTORS; k++) begin
				last_pos_q[k]  <= '0;
				speed_est_q[k] <= '0;
				last_err_q[k]  <= '0;
				err_integ_q[k] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_GAIN_P:       gain_p_q       <= cfg_data;
					CFG_GAIN_I:       gain_i_q       <= cfg_data;
					CFG_GAIN_D:       gain_d_q       <= cfg_data;
					CFG_INTEGRAL_CAP: integral_cap_q <= cfg_data;
					CFG_MAX_SPEED:    max_speed_q    <= cfg_data[14:0];
					CFG_MIN_WINDOW:   min_window_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= (int'(req.motor) < MOTORS) ? ST_LOAD : ST_DONE;
					end
				end
				ST_LOAD: state_q <= win_ok ? ST_SPD : ST_ERR;
				ST_SPD: begin
					if (div_done) begin
						speed_est_q[idx] <= spd_new;
						last_pos_q[idx]  <= req_q.encoder_position;
						state_q          <= ST_ERR;
					end
				end
				ST_ERR: state_q <= ST_DD;
				ST_DD: begin
					if (div_done) begin
						state_q <= ST_ET;
					end
				end
				ST_ET: begin
					if (mul_done) begin
						err_integ_q[idx] <= integ_sat[39:0];
						last_err_q[idx]  <= e_q;
						state_q          <= ST_P;
					end
				end
				ST_P: begin
					if (mul_done) begin
						state_q <= ST_D;
					end
				end
				ST_D: begin
					if (mul_done) begin
						state_q <= ST_I;
					end
				end
				ST_I: begin
					if (mul_done) begin
						state_q <= ST_IQ;
					end
				end
				ST_IQ: begin
					if (div_done) begin
						state_q <= ST_U;
					end
				end
				ST_U: state_q <= (v_neg || v_big) ? ST_DONE : ST_DUTY;
				ST_DUTY: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working values of the request in flight
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_q   <= req;
					spd_w_q <= '0;
					duty_q  <= '0;
				end
			end
			ST_LOAD: begin
				spd_w_q    <= speed_est_q[idx];
				diff_neg_q <= diff[32];
			end
			ST_SPD: begin
				if (div_done) begin
					spd_w_q <= spd_new;
				end
			end
			ST_ERR: begin
				e_q      <= e_comb;
				dd_neg_q <= dd[18];
			end
			ST_DD: begin
				if (div_done) begin
					dedt_mag_q <= div_quot[26:0];
				end
			end
			ST_ET: begin
				if (mul_done) begin
					integ_w_q <= integ_sat[39:0];
					acc_q     <= '0;
				end
			end
			ST_P: begin
				if (mul_done) begin
					acc_q <= e_q[17] ? acc_q - $signed(AccW'(mul_prod))
						: acc_q + $signed(AccW'(mul_prod));
				end
			end
			ST_D: begin
				if (mul_done) begin
					acc_q <= dd_neg_q ? acc_q - $signed(AccW'(mul_prod))
						: acc_q + $signed(AccW'(mul_prod));
				end
			end
			ST_IQ: begin
				if (div_done) begin
					acc_q <= integ_w_q[39] ? acc_q - $signed(AccW'(div_quot))
						: acc_q + $signed(AccW'(div_quot));
				end
			end
			ST_U: begin
				duty_q <= v_big ? 8'd255 : 8'd0;
			end
			ST_DUTY: begin
				if (div_done) begin
					duty_q <= div_quot[7:0];
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					rsp_q.motor_out      <= req_q.motor;
					rsp_q.duty           <= duty_q;
					rsp_q.measured_speed <= spd_w_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

endmodule
